[rtl/machine_cycle_sequencer_core_defines.svh]
// Assertion macros shared by the sequencer checker.
`ifndef MACHINE_CYCLE_SEQUENCER_CORE_DEFINES_SVH
`define MACHINE_CYCLE_SEQUENCER_CORE_DEFINES_SVH

// Clocked property, switched off while reset is asserted
`define MCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds while reset is asserted
`define MCS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mcs_pkg.sv]
// Types and constants for the machine cycle sequencer.
package mcs_pkg;

    // Subsystem status codes
    localparam logic [2:0] STAT_WAIT_INPUT = 3'd0;
    localparam logic [2:0] STAT_MOVING     = 3'd1;
    localparam logic [2:0] STAT_WAIT_HOME  = 3'd2;
    localparam logic [2:0] STAT_WAIT_READY = 3'd3;
    localparam logic [2:0] STAT_ABORTED    = 3'd4;

    // Command codes
    localparam logic [3:0] CMD_NONE       = 4'd0;
    localparam logic [3:0] CMD_READY      = 4'd1;
    localparam logic [3:0] CMD_HOME       = 4'd2;
    localparam logic [3:0] CMD_LOAD_BLADE = 4'd3;
    localparam logic [3:0] CMD_CUT        = 4'd4;
    localparam logic [3:0] CMD_CL_RECEIVE = 4'd5;
    localparam logic [3:0] CMD_CL_GRAB    = 4'd6;
    localparam logic [3:0] CMD_CL_SQUISH  = 4'd7;
    localparam logic [3:0] CMD_CL_OPEN    = 4'd8;
    localparam logic [3:0] CMD_RT_RECEIVE = 4'd9;
    localparam logic [3:0] CMD_RT_SQUISH  = 4'd10;
    localparam logic [3:0] CMD_RT_PRESQ   = 4'd11;
    localparam logic [3:0] CMD_LOAD_DRUM  = 4'd12;
    localparam logic [3:0] CMD_RELEASE    = 4'd13;

    localparam logic [15:0] CLAW_CLEAR_RESET = 16'd500;

    // Sequencer phases, in their external numbering
    typedef enum logic [4:0] {
        PH_SETUP,
        PH_HOME_DOORS,
        PH_CLOSE_CLAMPS,
        PH_HOME_ROT,
        PH_HOME_CLAMPS,
        PH_TO_READY,
        PH_WAIT_READY,
        PH_CLEAR_CLAWS,
        PH_BACK_RECEIVE,
        PH_AT_READY,
        PH_RUNNING,
        PH_LOADING,
        PH_RELEASING,
        PH_CLAMPING,
        PH_CUTTING,
        PH_PRESQUISH,
        PH_GRAB,
        PH_ROT_SQUISH,
        PH_CLAMP_SQUISH,
        PH_ROT_RECEIVE,
        PH_OPEN_CLAMP,
        PH_UNLOAD_FLAG,
        PH_UNLOAD_RELEASE
    } mcs_state_t;

    // One poll tick's inputs
    typedef struct packed {
        logic        run_button;
        logic        unload_button;
        logic [2:0]  drum_status;
        logic [2:0]  release_status;
        logic [2:0]  release_prev_status;
        logic [2:0]  cutter_status;
        logic [2:0]  cutter_prev_status;
        logic [2:0]  clamps_status;
        logic [2:0]  clamps_prev_status;
        logic [2:0]  rotators_status;
        logic [2:0]  rotators_prev_status;
        logic [15:0] rot_elapsed_ms;
    } mcs_item_t;

    // Commands for one tick
    typedef struct packed {
        logic [3:0] drum;
        logic [3:0] release_c;
        logic [3:0] cutter;
        logic [3:0] clamps;
        logic [3:0] rotators;
    } mcs_cmd_t;

    // A move has finished when a subsystem drops from moving to waiting input
    function automatic logic move_done(input logic [2:0] now_s, input logic [2:0] prev_s);
        return (now_s == STAT_WAIT_INPUT) && (prev_s == STAT_MOVING);
    endfunction

endpackage

[rtl/mcs_step.sv]
// Next-phase and command decode for one poll tick.
module mcs_step
    import mcs_pkg::*;
(
    input  mcs_state_t  state,
    input  mcs_item_t   item,
    input  logic [15:0] claw_clear_ms,
    output mcs_state_t  state_next,
    output mcs_cmd_t    cmd
);

    logic cut_done;
    logic clm_done;
    logic rot_done;
    logic rel_done;
    logic clm_idle;
    logic rot_idle;
    logic claw_timeout;
    logic to_cut;

    assign cut_done     = move_done(item.cutter_status, item.cutter_prev_status);
    assign clm_done     = move_done(item.clamps_status, item.clamps_prev_status);
    assign rot_done     = move_done(item.rotators_status, item.rotators_prev_status);
    assign rel_done     = move_done(item.release_status, item.release_prev_status);
    assign clm_idle     = (item.clamps_status == STAT_WAIT_INPUT);
    assign rot_idle     = (item.rotators_status == STAT_WAIT_INPUT);
    assign claw_timeout = (item.rotators_status == STAT_MOVING)
                          && (item.rot_elapsed_ms >= claw_clear_ms);
    assign to_cut       = clm_done && (item.cutter_status == STAT_WAIT_INPUT);

    // Next phase
    always_comb
    begin
        state_next = state;
        case (state)
            PH_SETUP:
                state_next = PH_HOME_DOORS;
            PH_HOME_DOORS:
                if (item.release_status == STAT_WAIT_INPUT)
                    state_next = PH_CLOSE_CLAMPS;
            PH_CLOSE_CLAMPS:
                if (item.clamps_status == STAT_WAIT_HOME
                    && item.rotators_status == STAT_WAIT_HOME)
                    state_next = PH_HOME_ROT;
            PH_HOME_ROT:
                if (item.rotators_status == STAT_WAIT_READY)
                    state_next = PH_HOME_CLAMPS;
            PH_HOME_CLAMPS:
                if (clm_idle)
                    state_next = PH_TO_READY;
            PH_TO_READY:
                state_next = PH_WAIT_READY;
            PH_WAIT_READY:
                if (cut_done && clm_done && rot_idle)
                    state_next = PH_CLEAR_CLAWS;
            PH_CLEAR_CLAWS:
                if (claw_timeout)
                    state_next = PH_BACK_RECEIVE;
            PH_BACK_RECEIVE:
                if (cut_done && clm_done && rot_done)
                    state_next = PH_AT_READY;
            PH_AT_READY, PH_RUNNING:
                if (item.unload_button)
                    state_next = PH_UNLOAD_FLAG;
                else if (item.run_button)
                    state_next = PH_LOADING;
            PH_LOADING:
                if (item.release_status == STAT_WAIT_INPUT
                    && item.drum_status == STAT_WAIT_INPUT)
                    state_next = PH_RELEASING;
            PH_RELEASING:
                if (rel_done && item.drum_status == STAT_WAIT_INPUT)
                    state_next = PH_CLAMPING;
            PH_CLAMPING:
                if (to_cut)
                    state_next = PH_CUTTING;
                else if (item.clamps_status == STAT_ABORTED)
                    state_next = PH_WAIT_READY;
            PH_CUTTING:
                if (cut_done && rot_idle)
                    state_next = PH_PRESQUISH;
            PH_PRESQUISH:
                if (rot_done && clm_idle)
                    state_next = PH_GRAB;
            PH_GRAB:
                if (clm_done && rot_idle)
                    state_next = PH_ROT_SQUISH;
            PH_ROT_SQUISH:
                if (rot_done && clm_idle)
                    state_next = PH_CLAMP_SQUISH;
            PH_CLAMP_SQUISH:
                if (clm_done && rot_idle)
                    state_next = PH_ROT_RECEIVE;
            PH_ROT_RECEIVE:
                if (rot_done && clm_idle)
                    state_next = PH_OPEN_CLAMP;
            PH_OPEN_CLAMP:
                if (clm_done && rot_idle)
                    state_next = PH_TO_READY;
            PH_UNLOAD_FLAG:
                if (cut_done)
                    state_next = PH_UNLOAD_RELEASE;
            PH_UNLOAD_RELEASE:
                if (cut_done)
                    state_next = PH_RUNNING;
            default:
                state_next = state;
        endcase
    end

    // Commands issued on this tick
    always_comb
    begin
        cmd = '{default: CMD_NONE};
        case (state)
            PH_HOME_DOORS:
                if (item.release_status == STAT_WAIT_INPUT)
                begin
                    cmd.drum      = CMD_READY;
                    cmd.release_c = CMD_READY;
                end
            PH_CLOSE_CLAMPS:
                if (item.clamps_status == STAT_WAIT_HOME
                    && item.rotators_status == STAT_WAIT_HOME)
                    cmd.rotators = CMD_HOME;
            PH_HOME_ROT:
                if (item.rotators_status == STAT_WAIT_READY)
                    cmd.clamps = CMD_HOME;
            PH_HOME_CLAMPS:
                if (clm_idle)
                begin
                    cmd.rotators = CMD_READY;
                    cmd.cutter   = CMD_READY;
                end
            PH_TO_READY:
            begin
                cmd.cutter   = CMD_LOAD_BLADE;
                cmd.clamps   = CMD_CL_RECEIVE;
                cmd.rotators = CMD_RT_RECEIVE;
            end
            PH_WAIT_READY:
                if (cut_done && clm_done && rot_idle)
                    cmd.rotators = CMD_RT_SQUISH;
            PH_CLEAR_CLAWS:
                if (claw_timeout)
                    cmd.rotators = CMD_RT_RECEIVE;
            PH_AT_READY, PH_RUNNING:
                if (item.unload_button)
                    cmd.cutter = CMD_LOAD_BLADE;
                else if (item.run_button)
                    cmd.drum = CMD_LOAD_DRUM;
            PH_LOADING:
                if (item.release_status == STAT_WAIT_INPUT
                    && item.drum_status == STAT_WAIT_INPUT)
                    cmd.release_c = CMD_RELEASE;
            PH_CLAMPING:
                if (to_cut)
                    cmd.cutter = CMD_CUT;
                else if (item.clamps_status == STAT_ABORTED)
                begin
                    // clamp abort: rearm and go back to the ready wait
                    cmd.cutter   = CMD_LOAD_BLADE;
                    cmd.clamps   = CMD_CL_RECEIVE;
                    cmd.rotators = CMD_RT_RECEIVE;
                end
            PH_CUTTING:
                if (cut_done && rot_idle)
                begin
                    cmd.cutter   = CMD_LOAD_BLADE;
                    cmd.rotators = CMD_RT_PRESQ;
                end
            PH_PRESQUISH:
                if (rot_done && clm_idle)
                    cmd.clamps = CMD_CL_GRAB;
            PH_GRAB:
                if (clm_done && rot_idle)
                    cmd.rotators = CMD_RT_SQUISH;
            PH_ROT_SQUISH:
                if (rot_done && clm_idle)
                    cmd.clamps = CMD_CL_SQUISH;
            PH_CLAMP_SQUISH:
                if (clm_done && rot_idle)
                    cmd.rotators = CMD_RT_RECEIVE;
            PH_ROT_RECEIVE:
                if (rot_done && clm_idle)
                    cmd.clamps = CMD_CL_OPEN;
            PH_UNLOAD_FLAG:
                if (cut_done)
                    cmd.cutter = CMD_CUT;
            default:
                cmd = '{default: CMD_NONE};
        endcase
    end

endmodule

[rtl/machine_cycle_sequencer_core.sv]
// Top level of the machine cycle sequencer: input register, phase decode, result register.
// One item is one poll tick. The block takes an item every clock unless a stalled result
// holds it back, and returns one result item per input item, in order; an accepted item
// is held in the input register and then decoded into the result register, where the
// result is presented. The phase register advances as each item passes the decode, so the
// following item already sees the new phase. claw_clear_ms resets to 500 and may be
// rewritten through cfg_we/cfg_wdata while no item is in flight.
module machine_cycle_sequencer_core
    import mcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: claw_clear_ms
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // tick inputs
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] run_button, [1] unload_button, [4:2] drum_status, [7:5] release_status,
    // [10:8] release_prev_status, [13:11] cutter_status, [16:14] cutter_prev_status,
    // [19:17] clamps_status, [22:20] clamps_prev_status, [25:23] rotators_status,
    // [28:26] rotators_prev_status, [44:29] rot_elapsed_ms, [47:45] zero
    input  logic [47:0] s_tdata,
    // commands
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] drum_cmd, [7:4] release_cmd, [11:8] cutter_cmd, [15:12] clamps_cmd,
    // [19:16] rotators_cmd, [24:20] phase, [31:25] zero
    output logic [31:0] m_tdata
);

    logic        in_valid_reg;
    logic        in_valid_next;
    mcs_item_t   in_item_reg;
    mcs_item_t   in_item_in;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_data_reg;
    mcs_state_t  state_reg;
    mcs_state_t  state_next;
    mcs_state_t  step_state;
    logic [15:0] claw_reg;
    logic [15:0] claw_next;
    mcs_cmd_t    step_cmd;
    logic        s_fire;
    logic        advance;

    // Unpack the incoming item
    assign in_item_in.run_button           = s_tdata[0];
    assign in_item_in.unload_button        = s_tdata[1];
    assign in_item_in.drum_status          = s_tdata[4:2];
    assign in_item_in.release_status       = s_tdata[7:5];
    assign in_item_in.release_prev_status  = s_tdata[10:8];
    assign in_item_in.cutter_status        = s_tdata[13:11];
    assign in_item_in.cutter_prev_status   = s_tdata[16:14];
    assign in_item_in.clamps_status        = s_tdata[19:17];
    assign in_item_in.clamps_prev_status   = s_tdata[22:20];
    assign in_item_in.rotators_status      = s_tdata[25:23];
    assign in_item_in.rotators_prev_status = s_tdata[28:26];
    assign in_item_in.rot_elapsed_ms       = s_tdata[44:29];

    // Handshake: the decode runs when an item waits and the result slot is free or its result is being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    mcs_step u_step (
        .state         (state_reg),
        .item          (in_item_reg),
        .claw_clear_ms (claw_reg),
        .state_next    (step_state),
        .cmd           (step_cmd)
    );

    // Control next values
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;

        state_next = advance ? step_state : state_reg;
        claw_next  = cfg_we ? cfg_wdata : claw_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= PH_SETUP;
            claw_reg      <= CLAW_CLEAR_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            claw_reg      <= claw_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_item_reg <= in_item_in;
        if (advance)
            out_data_reg <= {7'd0, step_state, step_cmd.rotators, step_cmd.clamps,
                             step_cmd.cutter, step_cmd.release_c, step_cmd.drum};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/mcs_checker.sv]
// Port-level checks for the machine cycle sequencer, bound to the top level.
`include "machine_cycle_sequencer_core_defines.svh"

module mcs_checker
    import mcs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic       stalled;
    logic       drum_ok;
    logic [4:0] phase_out;

    assign stalled   = m_tvalid && !m_tready;
    assign phase_out = m_tdata[24:20];
    assign drum_ok   = (m_tdata[3:0] == CMD_NONE) || (m_tdata[3:0] == CMD_READY)
                       || (m_tdata[3:0] == CMD_LOAD_DRUM);

    // No result leaves in the cycle after reset was seen
    `MCS_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |=> !m_tvalid, "result valid after reset")

    // A stalled result holds its value
    `MCS_ASSERT(a_result_hold, stalled |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // With the result side drained the input is always open
    `MCS_ASSERT(a_ready_when_drained, !m_tvalid |-> s_tready, "input blocked while drained")

    // Reported phase stays within the defined phases
    `MCS_ASSERT(a_phase_range, m_tvalid |-> phase_out <= PH_UNLOAD_RELEASE, "phase out of range")

    // Drum only ever gets none, ready or load drum
    `MCS_ASSERT(a_drum_cmd, m_tvalid |-> drum_ok, "bad drum command")

endmodule

bind machine_cycle_sequencer_core mcs_checker u_mcs_checker (.*);
